// ===== rtl/rrca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rrca_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_PAYLOAD = 4000;

    localparam int SEQ_W    = 32;
    localparam int SIZE_W   = 12;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 2;
    localparam int PTR_W    = $clog2(SLOTS);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINACK  = 2'd2;

    // input op codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_FIN  = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [SIZE_W-1:0]   size;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

    // offset advance, saturating at all ones
    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] base,
                                                 input logic [SIZE_W-1:0] inc);
        logic [SEQ_W:0] sum;
        sum = {1'b0, base} + (SEQ_W+1)'(inc);
        return sum[SEQ_W] ? {SEQ_W{1'b1}} : sum[SEQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/reorder_receiver_cumulative_ack.sv =====
// Timing: a FIN or behind-window packet goes straight to the response step; an ahead-of-window
// packet first takes one slot memory pass (one entry per cycle). In-order: deliver, then
// a circular scan that ends after SLOTS consecutive misses; each delivered slot restarts it,
// and output stalls hold the scan.
// Flow: one packet at a time; a new packet is taken only once the last one is done.
// Reset: async, clears offset, finished flag, slot valid bits and handshake state; no memory pass.
`timescale 1ns / 1ps
`default_nettype none

module reorder_receiver_cumulative_ack
    import rrca_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // seq_number[31:0], payload_size[43:32],
                                             // payload_handle[59:44], zero pad
    input  wire logic        s_axis_tuser,   // op

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // out_handle[15:0], out_size[27:16],
                                             // ack_number[59:28], dropped[60], zero pad
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last
);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RESP    = 3'd1;  // single ack / finack
    localparam logic [2:0] ST_AHEAD   = 3'd2;  // duplicate search, then store
    localparam logic [2:0] ST_DELIVER = 3'd3;  // deliver the in-order packet itself
    localparam logic [2:0] ST_DRAIN   = 3'd4;  // circular scan for follow-on slots

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(SLOTS - 1);

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    logic                in_op;
    logic [SEQ_W-1:0]    in_seq;
    logic [SIZE_W-1:0]   in_size_raw;
    logic [SIZE_W-1:0]   in_size;
    logic [HANDLE_W-1:0] in_handle;

    assign in_op       = s_axis_tuser;
    assign in_seq      = s_axis_tdata[31:0];
    assign in_size_raw = s_axis_tdata[43:32];
    assign in_handle   = s_axis_tdata[59:44];
    // oversize payload clamps to the max
    assign in_size = (32'(in_size_raw) > 32'(MAX_PAYLOAD)) ? SIZE_W'(MAX_PAYLOAD) : in_size_raw;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [2:0]          state_reg, state_next;
    logic [SEQ_W-1:0]    exp_reg, exp_next;
    logic                finished_reg, finished_next;
    logic [SLOTS-1:0]    slot_valid_reg, slot_valid_next;

    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [PTR_W-1:0]    cnt_reg, cnt_next;

    logic [SEQ_W-1:0]    in_seq_reg, in_seq_next;
    logic [SIZE_W-1:0]   in_size_reg, in_size_next;
    logic [HANDLE_W-1:0] in_handle_reg, in_handle_next;
    logic [KIND_W-1:0]   resp_kind_reg, resp_kind_next;
    logic                drop_reg, drop_next;
    logic                dup_reg, dup_next;

    logic                out_valid_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [SIZE_W-1:0]   out_size_reg;
    logic [SEQ_W-1:0]    out_ack_reg;
    logic                out_drop_reg;
    logic                out_last_reg;

    // ------------------------------------------------------------------
    // Slot memory: one write port, one registered read port
    // ------------------------------------------------------------------
    slot_t               slot_mem [SLOTS];
    slot_t               rd_data_reg;
    logic                mem_re;
    logic                mem_we;
    logic [PTR_W-1:0]    wr_idx;
    slot_t               wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_idx] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[rd_ptr_reg];
        end
    end

    // lowest free slot
    logic                free_any;
    logic [PTR_W-1:0]    free_idx;

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = PTR_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Check stage (entry read last cycle)
    // ------------------------------------------------------------------
    logic chk_live;
    logic seq_eq_exp;
    logic seq_lt_exp;
    logic seq_eq_in;
    logic out_free;

    assign chk_live   = chk_valid_reg && slot_valid_reg[chk_idx_reg];
    assign seq_eq_exp = chk_live && (rd_data_reg.seq == exp_reg);
    assign seq_lt_exp = chk_live && (rd_data_reg.seq < exp_reg);
    assign seq_eq_in  = chk_live && (rd_data_reg.seq == in_seq_reg);
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);

    // result load
    logic                emit;
    logic [KIND_W-1:0]   emit_kind;
    logic [HANDLE_W-1:0] emit_handle;
    logic [SIZE_W-1:0]   emit_size;
    logic [SEQ_W-1:0]    emit_ack;
    logic                emit_drop;
    logic                emit_last;

    logic                dup_now;
    logic                scan_adv;

    always_comb
    begin
        state_next      = state_reg;
        exp_next        = exp_reg;
        finished_next   = finished_reg;
        slot_valid_next = slot_valid_reg;
        rd_ptr_next     = rd_ptr_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = chk_valid_reg;
        cnt_next        = cnt_reg;
        in_seq_next     = in_seq_reg;
        in_size_next    = in_size_reg;
        in_handle_next  = in_handle_reg;
        resp_kind_next  = resp_kind_reg;
        drop_next       = drop_reg;
        dup_next        = dup_reg;

        mem_re  = 1'b0;
        mem_we  = 1'b0;
        wr_idx  = free_idx;
        wr_data = '{seq: in_seq_reg, size: in_size_reg, handle: in_handle_reg};

        emit        = 1'b0;
        emit_kind   = KIND_ACK;
        emit_handle = '0;
        emit_size   = '0;
        emit_ack    = exp_reg;
        emit_drop   = 1'b0;
        emit_last   = 1'b1;

        dup_now  = dup_reg || seq_eq_in;
        // a hit holds the scan until the result register frees up
        scan_adv = !(state_reg == ST_DRAIN && seq_eq_exp && !out_free);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    in_seq_next    = in_seq;
                    in_size_next   = in_size;
                    in_handle_next = in_handle;
                    drop_next      = 1'b0;
                    dup_next       = 1'b0;
                    rd_ptr_next    = '0;
                    chk_valid_next = 1'b0;
                    cnt_next       = '0;
                    if (finished_reg)
                    begin
                        state_next = ST_IDLE;       // ignored after fin
                    end
                    else if (in_op == OP_FIN)
                    begin
                        finished_next  = 1'b1;
                        resp_kind_next = KIND_FINACK;
                        state_next     = ST_RESP;
                    end
                    else if (in_seq < exp_reg)
                    begin
                        resp_kind_next = KIND_ACK;
                        state_next     = ST_RESP;
                    end
                    else if (in_seq > exp_reg)
                    begin
                        state_next = ST_AHEAD;
                    end
                    else
                    begin
                        state_next = ST_DELIVER;
                    end
                end
            end

            ST_RESP:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = resp_kind_reg;
                    emit_drop  = drop_reg;
                    state_next = ST_IDLE;
                end
            end

            ST_AHEAD:
            begin
                mem_re         = 1'b1;
                rd_ptr_next    = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
                chk_idx_next   = rd_ptr_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg)
                begin
                    dup_next = dup_now;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == LAST_IDX)
                    begin
                        if (!dup_now)
                        begin
                            if (free_any)
                            begin
                                mem_we                    = 1'b1;
                                slot_valid_next[free_idx] = 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        resp_kind_next = KIND_ACK;
                        state_next     = ST_RESP;
                    end
                end
            end

            ST_DELIVER:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_kind   = KIND_DELIVER;
                    emit_handle = in_handle_reg;
                    emit_size   = in_size_reg;
                    emit_ack    = '0;
                    emit_last   = 1'b0;
                    exp_next    = sat_add(exp_reg, in_size_reg);
                    state_next  = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                if (scan_adv)
                begin
                    mem_re         = 1'b1;
                    rd_ptr_next    = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
                    chk_idx_next   = rd_ptr_reg;
                    chk_valid_next = 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (seq_eq_exp)
                    begin
                        if (out_free)
                        begin
                            emit        = 1'b1;
                            emit_kind   = KIND_DELIVER;
                            emit_handle = rd_data_reg.handle;
                            emit_size   = rd_data_reg.size;
                            emit_ack    = '0;
                            emit_last   = 1'b0;
                            exp_next    = sat_add(exp_reg, rd_data_reg.size);
                            slot_valid_next[chk_idx_reg] = 1'b0;
                            cnt_next    = '0;
                        end
                    end
                    else
                    begin
                        // offset only grows, so a stale slot can go at once
                        if (seq_lt_exp)
                        begin
                            slot_valid_next[chk_idx_reg] = 1'b0;
                        end
                        if (cnt_reg == LAST_IDX)
                        begin
                            resp_kind_next = KIND_ACK;
                            state_next     = ST_RESP;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            exp_reg        <= '0;
            finished_reg   <= 1'b0;
            slot_valid_reg <= '0;
            rd_ptr_reg     <= '0;
            chk_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
            resp_kind_reg  <= KIND_ACK;
            drop_reg       <= 1'b0;
            dup_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            exp_reg        <= exp_next;
            finished_reg   <= finished_next;
            slot_valid_reg <= slot_valid_next;
            rd_ptr_reg     <= rd_ptr_next;
            chk_idx_reg    <= chk_idx_next;
            chk_valid_reg  <= chk_valid_next;
            cnt_reg        <= cnt_next;
            resp_kind_reg  <= resp_kind_next;
            drop_reg       <= drop_next;
            dup_reg        <= dup_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_seq_reg    <= in_seq_next;
        in_size_reg   <= in_size_next;
        in_handle_reg <= in_handle_next;
        if (emit)
        begin
            out_kind_reg   <= emit_kind;
            out_handle_reg <= emit_handle;
            out_size_reg   <= emit_size;
            out_ack_reg    <= emit_ack;
            out_drop_reg   <= emit_drop;
            out_last_reg   <= emit_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_drop_reg, out_ack_reg, out_size_reg, out_handle_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result loaded over a pending transfer");

    a_offset_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> exp_reg >= $past(exp_reg))
        else $error("expected offset moved backwards");

    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared without reset");

    a_write_only_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_AHEAD) && !slot_valid_reg[wr_idx])
        else $error("slot write outside store step or into a live slot");

    a_drain_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> $past(slot_valid_reg) >= slot_valid_reg
                                    || state_reg != ST_DRAIN)
        else $error("drain set a slot valid bit");

endmodule

`default_nettype wire
